// ----- src/spdlq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sine PWM duty level quantizer package
// Shared constants, register map, sequencer states and series tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spdlq_pkg;

  // Field widths of the transaction ports
  localparam int IDX_W      = 10;
  localparam int DUTY_W     = 17;
  localparam int LEVEL_W    = 8;
  localparam int SP_W       = 11;
  localparam int PWM_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Phase is one full turn in 32 bits
  localparam int PHASE_W = 32;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_SPAN      = 8'd1;

  // Reset values of the registers
  localparam logic [SP_W-1:0]  SIGNAL_PERIOD_RST = 11'd1024;
  localparam logic [PWM_W-1:0] PWM_SPAN_RST      = 16'd256;

  // Input mode codes
  localparam logic MODE_SINE  = 1'b0;
  localparam logic MODE_FIXED = 1'b1;

  // Fixed point constants
  localparam logic [31:0] Q30_ONE  = 32'h4000_0000;
  localparam logic [31:0] PI_Q30   = 32'hC90F_DAA2;
  localparam logic [31:0] HALF_Q15 = 32'h0000_4000;
  localparam logic [16:0] Q16_ONE  = 17'h1_0000;
  localparam logic [15:0] Q16_HALF = 16'h8000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // Number of Horner steps in the sine series
  localparam int NUM_TERMS = 6;
  localparam int TERM_W    = 3;

  // Sequencer states
  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00_0000_0000_0001,
    ST_DIV   = 14'b00_0000_0000_0010,
    ST_FOLD  = 14'b00_0000_0000_0100,
    ST_MX    = 14'b00_0000_0000_1000,
    ST_MX2   = 14'b00_0000_0001_0000,
    ST_X2    = 14'b00_0000_0010_0000,
    ST_TA    = 14'b00_0000_0100_0000,
    ST_TB    = 14'b00_0000_1000_0000,
    ST_TC    = 14'b00_0001_0000_0000,
    ST_TD    = 14'b00_0010_0000_0000,
    ST_SX    = 14'b00_0100_0000_0000,
    ST_SUM   = 14'b00_1000_0000_0000,
    ST_LMUL  = 14'b01_0000_0000_0000,
    ST_LPICK = 14'b10_0000_0000_0000
  } state_e;

  // Series divisor of Horner step i
  function automatic logic [7:0] series_div(input logic [TERM_W-1:0] i);
    logic [7:0] d;
    case (i)
      3'd0:    d = 8'd156;
      3'd1:    d = 8'd110;
      3'd2:    d = 8'd72;
      3'd3:    d = 8'd42;
      3'd4:    d = 8'd20;
      3'd5:    d = 8'd6;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) of Horner step i
  function automatic logic [31:0] series_recip(input logic [TERM_W-1:0] i);
    logic [31:0] m;
    case (i)
      3'd0:    m = 32'd27531841;
      3'd1:    m = 32'd39045157;
      3'd2:    m = 32'd59652323;
      3'd3:    m = 32'd102261126;
      3'd4:    m = 32'd214748364;
      3'd5:    m = 32'd715827882;
      default: m = 32'd715827882;
    endcase
    return m;
  endfunction

endpackage

// ----- src/spdlq_div.sv -----
// ----------------------------------------------------------------------------
// Phase divider
// Radix-2 restoring division of (index << 32) by the sine period, one
// quotient bit per cycle; returns the quotient modulo one turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spdlq_div #(
  parameter int PW = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [spdlq_pkg::IDX_W-1:0]   index_i,
  input  logic [PW-1:0]                 divisor_i,
  output logic                          done_o,
  output logic [spdlq_pkg::PHASE_W-1:0] quotient_o
);

  localparam int STEPS = spdlq_pkg::IDX_W + spdlq_pkg::PHASE_W;
  localparam int CW    = $clog2(STEPS);

  logic                          busy_q;
  logic                          done_q;
  logic [CW-1:0]                 cnt_q;
  logic [PW-1:0]                 rem_q;
  logic [PW-1:0]                 rem_d;
  logic [PW-1:0]                 div_q;
  logic [spdlq_pkg::IDX_W-1:0]   num_q;
  logic [spdlq_pkg::PHASE_W-1:0] quo_q;
  logic [PW:0]                   trial;
  logic                          ge;

  // Shift in the next dividend bit and try one subtraction
  always_comb begin
    trial = {rem_q, num_q[spdlq_pkg::IDX_W-1]};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? PW'(trial - {1'b0, div_q}) : trial[PW-1:0];
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Hold the partial remainder, dividend bits and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= index_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      num_q <= {num_q[spdlq_pkg::IDX_W-2:0], 1'b0};
      quo_q <= {quo_q[spdlq_pkg::PHASE_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/sine_pwm_duty_level_quantizer.sv -----
// ----------------------------------------------------------------------------
// Sine PWM duty level quantizer
// Maps a sine sample or a fixed duty fraction to the nearest PWM duty level.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. A sine-mode transaction first
// passes through the bit-serial phase divider (42 quotient bits plus the
// hand-off), then through the steps in which one shared 32x32 multiplier
// works through the range reduction, the six-step Taylor series of the sine
// (each series division done as a reciprocal product with one correction)
// and the level product. A fixed-mode transaction skips the sine and goes
// straight to the level product. The input stalls while a transaction is in
// flight and opens again once the result is loaded. A finished result sits
// in an output register so the next transaction can start before it is taken;
// while that register is still held, the next result waits in the last step.
// The level index is the nearest of min(MAX_LEVELS, PWM span) levels,
// found in closed form from target * N. Registers are to be written through
// the configuration port only while the block is idle; the block itself does
// not enforce this, and cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_pwm_duty_level_quantizer #(
  parameter int MAX_LEVELS  = 256,
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input transactions
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic [spdlq_pkg::IDX_W-1:0]        sample_index_i,
  input  logic [spdlq_pkg::DUTY_W-1:0]       duty_fraction_i,
  // Result transactions
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [spdlq_pkg::LEVEL_W-1:0]      level_index_o,
  // Configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [spdlq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spdlq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int P_CAP = (MAX_SAMPLES < 2047) ? MAX_SAMPLES : 2047;
  localparam int PW    = $clog2(P_CAP + 1);
  localparam int LW    = $clog2(MAX_LEVELS + 1);
  localparam int TNW   = spdlq_pkg::DUTY_W + LW;

  spdlq_pkg::state_e state_q, state_d;

  logic [spdlq_pkg::SP_W-1:0]   sp_q;
  logic [spdlq_pkg::PWM_W-1:0]  pwm_q;

  logic                         in_accept;
  logic                         div_start;
  logic                         div_done;
  logic [31:0]                  div_quo;
  logic [PW-1:0]                p_eff;
  logic [LW-1:0]                n_eff;

  logic [31:0]                  phase_q;
  logic [30:0]                  mag_q;
  logic                         neg_q;
  logic [30:0]                  x_q;
  logic [31:0]                  x2_q;
  logic [30:0]                  t_q;
  logic [31:0]                  a_q;
  logic [31:0]                  qa_q;
  logic [spdlq_pkg::TERM_W-1:0] term_q;
  logic [16:0]                  target_q;

  logic                         mul_en;
  logic [31:0]                  mul_a;
  logic [31:0]                  mul_b;
  logic [63:0]                  prod_q;

  logic                         out_valid_q;
  logic [spdlq_pkg::LEVEL_W-1:0] level_q;
  logic                         out_load;

  // Fold and series signals
  logic [31:0]                  folded;
  logic [31:0]                  mag_full;
  logic [31:0]                  rem_fix;
  logic [32:0]                  q_fix;
  logic [30:0]                  t_next;
  logic [32:0]                  s_raw;
  logic [30:0]                  s_clamp;
  logic [31:0]                  sum_v;
  logic [16:0]                  tgt_sine;
  logic [16:0]                  tgt_fixed;

  // Level pick signals
  logic [TNW-1:0]               tn;
  logic [LW:0]                  k;
  logic [LW:0]                  c0;
  logic [LW:0]                  c;
  logic [TNW-1:0]               lv;
  logic [TNW-1:0]               dj;
  logic                         pick0;
  logic [LW+8:0]                jw;
  logic [spdlq_pkg::LEVEL_W-1:0] level_d;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != spdlq_pkg::ST_IDLE);
  assign div_start  = in_accept && (mode_i == spdlq_pkg::MODE_SINE);
  assign cfg_ready_o = 1'b1;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= spdlq_pkg::SIGNAL_PERIOD_RST;
      pwm_q <= spdlq_pkg::PWM_SPAN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spdlq_pkg::REG_SIGNAL_PERIOD: sp_q  <= cfg_data_i[spdlq_pkg::SP_W-1:0];
        spdlq_pkg::REG_PWM_SPAN:      pwm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the sine period and the level count
  always_comb begin
    if (sp_q == '0) begin
      p_eff = PW'(1);
    end else if (32'(sp_q) > 32'(MAX_SAMPLES)) begin
      p_eff = PW'(P_CAP);
    end else begin
      p_eff = PW'(sp_q);
    end
    n_eff = (32'(pwm_q) > 32'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : LW'(pwm_q);
  end

  spdlq_div #(
    .PW(PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .index_i    (sample_index_i),
    .divisor_i  (p_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Fold the phase into a quarter turn, apply the series step and form the duty targets
  always_comb begin
    if (phase_q[31:30] == 2'b01 || phase_q[31:30] == 2'b10) begin
      folded = spdlq_pkg::HALF_TURN - phase_q;
    end else begin
      folded = phase_q;
    end
    mag_full = folded[31] ? (32'd0 - folded) : folded;

    rem_fix = a_q - prod_q[31:0];
    q_fix   = {1'b0, qa_q} +
              33'((rem_fix >= 32'(spdlq_pkg::series_div(term_q))) ? 1 : 0);
    t_next  = (q_fix >= {1'b0, spdlq_pkg::Q30_ONE}) ? '0
              : 31'(spdlq_pkg::Q30_ONE - q_fix[31:0]);

    s_raw   = prod_q[62:30];
    s_clamp = (s_raw > 33'(spdlq_pkg::Q30_ONE)) ? 31'(spdlq_pkg::Q30_ONE) : s_raw[30:0];
    if (neg_q) begin
      sum_v = spdlq_pkg::Q30_ONE - 32'(s_clamp) + spdlq_pkg::HALF_Q15;
    end else begin
      sum_v = spdlq_pkg::Q30_ONE + 32'(s_clamp) + spdlq_pkg::HALF_Q15;
    end
    tgt_sine  = (sum_v[31:15] > spdlq_pkg::Q16_ONE) ? spdlq_pkg::Q16_ONE : sum_v[31:15];
    tgt_fixed = (duty_fraction_i > spdlq_pkg::Q16_ONE) ? spdlq_pkg::Q16_ONE
                : duty_fraction_i;
  end

  // Pick the nearest level from target * N
  always_comb begin
    tn    = prod_q[TNW-1:0];
    k     = tn[TNW-1:16];
    c0    = (tn[15:0] > spdlq_pkg::Q16_HALF) ? (k + (LW+1)'(1)) : k;
    if (c0 < (LW+1)'(2)) begin
      c = (LW+1)'(2);
    end else if (c0 > {1'b0, n_eff}) begin
      c = {1'b0, n_eff};
    end else begin
      c = c0;
    end
    lv    = {c, 16'h0000};
    dj    = (lv >= tn) ? (lv - tn) : (tn - lv);
    pick0 = (n_eff < LW'(2)) || (tn <= dj);
    jw    = pick0 ? '0 : ((LW+9)'(c) - (LW+9)'(1));
    level_d = jw[spdlq_pkg::LEVEL_W-1:0];
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      spdlq_pkg::ST_MX: begin
        mul_en = 1'b1;
        mul_a  = 32'(mag_q);
        mul_b  = spdlq_pkg::PI_Q30;
      end
      spdlq_pkg::ST_MX2: begin
        mul_en = 1'b1;
        mul_a  = prod_q[62:31];
        mul_b  = prod_q[62:31];
      end
      spdlq_pkg::ST_TA: begin
        mul_en = 1'b1;
        mul_a  = x2_q;
        mul_b  = 32'(t_q);
      end
      spdlq_pkg::ST_TB: begin
        mul_en = 1'b1;
        mul_a  = prod_q[61:30];
        mul_b  = spdlq_pkg::series_recip(term_q);
      end
      spdlq_pkg::ST_TC: begin
        mul_en = 1'b1;
        mul_a  = prod_q[63:32];
        mul_b  = 32'(spdlq_pkg::series_div(term_q));
      end
      spdlq_pkg::ST_SX: begin
        mul_en = 1'b1;
        mul_a  = 32'(x_q);
        mul_b  = 32'(t_q);
      end
      spdlq_pkg::ST_LMUL: begin
        mul_en = 1'b1;
        mul_a  = 32'(target_q);
        mul_b  = 32'(n_eff);
      end
      default: ;
    endcase
  end

  // Register the shared product
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  assign out_load = (state_q == spdlq_pkg::ST_LPICK) && (!out_valid_q || !out_stall_i);

  // Sequence the steps of one transaction
  always_comb begin
    state_d = state_q;
    case (state_q)
      spdlq_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = (mode_i == spdlq_pkg::MODE_SINE) ? spdlq_pkg::ST_DIV
                    : spdlq_pkg::ST_LMUL;
        end
      end
      spdlq_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = spdlq_pkg::ST_FOLD;
        end
      end
      spdlq_pkg::ST_FOLD:  state_d = spdlq_pkg::ST_MX;
      spdlq_pkg::ST_MX:    state_d = spdlq_pkg::ST_MX2;
      spdlq_pkg::ST_MX2:   state_d = spdlq_pkg::ST_X2;
      spdlq_pkg::ST_X2:    state_d = spdlq_pkg::ST_TA;
      spdlq_pkg::ST_TA:    state_d = spdlq_pkg::ST_TB;
      spdlq_pkg::ST_TB:    state_d = spdlq_pkg::ST_TC;
      spdlq_pkg::ST_TC:    state_d = spdlq_pkg::ST_TD;
      spdlq_pkg::ST_TD: begin
        state_d = (term_q == spdlq_pkg::TERM_W'(spdlq_pkg::NUM_TERMS - 1))
                  ? spdlq_pkg::ST_SX : spdlq_pkg::ST_TA;
      end
      spdlq_pkg::ST_SX:    state_d = spdlq_pkg::ST_SUM;
      spdlq_pkg::ST_SUM:   state_d = spdlq_pkg::ST_LMUL;
      spdlq_pkg::ST_LMUL:  state_d = spdlq_pkg::ST_LPICK;
      spdlq_pkg::ST_LPICK: begin
        if (out_load) begin
          state_d = spdlq_pkg::ST_IDLE;
        end
      end
      default:             state_d = spdlq_pkg::ST_IDLE;
    endcase
  end

  // Advance the sequencer and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spdlq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the intermediate values of the datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      spdlq_pkg::ST_IDLE: begin
        if (in_accept) begin
          target_q <= tgt_fixed;
        end
      end
      spdlq_pkg::ST_DIV: begin
        if (div_done) begin
          phase_q <= div_quo;
        end
      end
      spdlq_pkg::ST_FOLD: begin
        mag_q <= mag_full[30:0];
        neg_q <= folded[31];
      end
      spdlq_pkg::ST_MX2: begin
        x_q <= prod_q[61:31];
      end
      spdlq_pkg::ST_X2: begin
        x2_q   <= prod_q[61:30];
        t_q    <= 31'(spdlq_pkg::Q30_ONE);
        term_q <= '0;
      end
      spdlq_pkg::ST_TB: begin
        a_q <= prod_q[61:30];
      end
      spdlq_pkg::ST_TC: begin
        qa_q <= prod_q[63:32];
      end
      spdlq_pkg::ST_TD: begin
        t_q    <= t_next;
        term_q <= term_q + spdlq_pkg::TERM_W'(1);
      end
      spdlq_pkg::ST_SUM: begin
        target_q <= tgt_sine;
      end
      spdlq_pkg::ST_LPICK: begin
        if (out_load) begin
          level_q <= level_d;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign level_index_o = level_q;

endmodule

// ----- test/duty_level_checker.sv -----
// ----------------------------------------------------------------------------
// Duty level checker
// Watches the input, result and configuration channels of the duty level
// quantizer, predicts the level index of every accepted input transaction and
// compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module duty_level_checker #(
  parameter int MAX_LEVELS  = 256,
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             mode_i,
  input  logic [spdlq_pkg::IDX_W-1:0]      sample_index_i,
  input  logic [spdlq_pkg::DUTY_W-1:0]     duty_fraction_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [spdlq_pkg::LEVEL_W-1:0]    level_index_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [spdlq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [spdlq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                               mismatch_count_o,
  output int                               pending_levels_o
);

  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] PI_RAD_Q30 = 64'd3373259426;
  localparam logic [63:0] FULL_DUTY  = 64'd65536;
  localparam logic [63:0] ROUND_Q15  = 64'd16384;
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

  typedef struct {
    logic                           mode;
    logic [spdlq_pkg::IDX_W-1:0]    idx;
    logic [spdlq_pkg::DUTY_W-1:0]   duty;
    logic [spdlq_pkg::LEVEL_W-1:0]  level;
  } level_pred_t;

  level_pred_t                  expected_levels[$];
  logic [spdlq_pkg::SP_W-1:0]   sig_period_q;
  logic [spdlq_pkg::PWM_W-1:0]  pwm_span_q;

  // Divisor of each Horner step of the sine series, innermost first
  function automatic logic [63:0] horner_divisor(input int k);
    case (k)
      0:       return 64'd156;
      1:       return 64'd110;
      2:       return 64'd72;
      3:       return 64'd42;
      4:       return 64'd20;
      default: return 64'd6;
    endcase
  endfunction

  // Target duty in Q1.16 for one transaction
  function automatic logic [63:0] duty_target_q16(
      input logic                          mode,
      input logic [spdlq_pkg::IDX_W-1:0]   idx,
      input logic [spdlq_pkg::DUTY_W-1:0]  duty,
      input logic [spdlq_pkg::SP_W-1:0]    sp);
    logic [63:0] period, quot, x, x2, t, prod, s, sum, target;
    logic [31:0] phase, folded, mag;
    logic        neg;
    int          k;
    if (mode == spdlq_pkg::MODE_FIXED) begin
      return (64'(duty) > FULL_DUTY) ? FULL_DUTY : 64'(duty);
    end
    // Clamp the period, then turn the index into a 32-bit phase
    period = 64'(sp);
    if (period == 64'd0) period = 64'd1;
    if (period > 64'(MAX_SAMPLES)) period = 64'(MAX_SAMPLES);
    quot  = (64'(idx) << 32) / period;
    phase = quot[31:0];
    // Fold into a quarter turn either side of zero
    folded = phase;
    if (phase[31:30] == 2'b01 || phase[31:30] == 2'b10) folded = HALF_TURN - phase;
    neg = folded[31];
    mag = neg ? (32'd0 - folded) : folded;
    // Taylor series in Horner form, every step floored
    x  = (64'(mag) * PI_RAD_Q30) >> 31;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (k = 0; k < 6; k++) begin
      prod = ((x2 * t) >> 30) / horner_divisor(k);
      t = (prod >= ONE_Q30) ? 64'd0 : ONE_Q30 - prod;
    end
    s = (x * t) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    sum = neg ? (ONE_Q30 - s + ROUND_Q15) : (ONE_Q30 + s + ROUND_Q15);
    target = sum >> 15;
    return (target > FULL_DUTY) ? FULL_DUTY : target;
  endfunction

  // Nearest of the non-uniform duty levels, lowest index on a tie
  function automatic logic [spdlq_pkg::LEVEL_W-1:0] nearest_duty_level(
      input logic [63:0]                  target,
      input logic [spdlq_pkg::PWM_W-1:0]  pwm);
    logic [63:0] tn, lv, delta, best;
    int unsigned n, j, best_j;
    n = (int'(pwm) < MAX_LEVELS) ? int'(pwm) : MAX_LEVELS;
    tn = target * 64'(n);
    best = 64'd0;
    best_j = 0;
    for (j = 0; j < n; j++) begin
      lv = (j == 0) ? 64'd0 : 64'(j + 1) * FULL_DUTY;
      delta = (lv >= tn) ? lv - tn : tn - lv;
      if (j == 0 || delta < best) begin
        best = delta;
        best_j = j;
      end
    end
    return best_j[spdlq_pkg::LEVEL_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: level check failed: %s", $time, msg);
    mismatch_count_o++;
  endtask

  // Compare results, queue predictions, track register writes
  always @(posedge clk_i or negedge rst_ni) begin : watch
    level_pred_t head, pred;
    if (!rst_ni) begin
      sig_period_q     <= spdlq_pkg::SIGNAL_PERIOD_RST;
      pwm_span_q       <= spdlq_pkg::PWM_SPAN_RST;
      pending_levels_o <= 0;
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("result level_index=%0d with no transaction pending",
                                    level_index_i));
        end else begin
          head = expected_levels.pop_front();
          if (level_index_i !== head.level) begin
            report_mismatch($sformatf("mode=%0d idx=%0d duty=%0d level_index got %0d want %0d",
                                      head.mode, head.idx, head.duty, level_index_i,
                                      head.level));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pred.mode  = mode_i;
        pred.idx   = sample_index_i;
        pred.duty  = duty_fraction_i;
        pred.level = nearest_duty_level(
            duty_target_q16(mode_i, sample_index_i, duty_fraction_i, sig_period_q),
            pwm_span_q);
        expected_levels.push_back(pred);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          spdlq_pkg::REG_SIGNAL_PERIOD: sig_period_q <= cfg_data_i[spdlq_pkg::SP_W-1:0];
          spdlq_pkg::REG_PWM_SPAN:      pwm_span_q   <= cfg_data_i[spdlq_pkg::PWM_W-1:0];
          default: ;
        endcase
      end
      pending_levels_o <= expected_levels.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Duty level quantizer testbench
// Drives sine and fixed duty transactions through the quantizer under a
// range of register settings, with bursty input and random result stalls,
// and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_LEVELS  = 256;
  localparam int MAX_SAMPLES = 1024;
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES  = 13;
  localparam int PHASE_ITEMS = 120;

  // Register indexes outside the map, expected to be ignored
  localparam logic [spdlq_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [spdlq_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_mode = spdlq_pkg::MODE_SINE;
  logic [spdlq_pkg::IDX_W-1:0]      in_idx = '0;
  logic [spdlq_pkg::DUTY_W-1:0]     in_duty = '0;
  logic                             out_stall = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic [spdlq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [spdlq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                             in_stall_o;
  logic                             out_valid_o;
  logic [spdlq_pkg::LEVEL_W-1:0]    level_index_o;
  logic                             cfg_ready_o;

  int mismatch_count;
  int pending_levels;
  int stuck_cycles = 0;
  int burst_left = 0;
  int gap_max = 2;
  bit hold_req = 1'b0;

  always #10 clk = ~clk;

  sine_pwm_duty_level_quantizer #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .mode_i         (in_mode),
    .sample_index_i (in_idx),
    .duty_fraction_i(in_duty),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .level_index_o  (level_index_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  duty_level_checker #(
    .MAX_LEVELS (MAX_LEVELS),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall_o),
    .mode_i          (in_mode),
    .sample_index_i  (in_idx),
    .duty_fraction_i (in_duty),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall),
    .level_index_i   (level_index_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .pending_levels_o(pending_levels)
  );

  // Offer one transaction and hold it until accepted
  task automatic send_item(input logic mode, input logic [spdlq_pkg::IDX_W-1:0] idx,
                           input logic [spdlq_pkg::DUTY_W-1:0] duty);
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_idx   <= idx;
    in_duty  <= duty;
    do @(posedge clk); while (in_stall_o);
  endtask

  // Keep the burst going or drop valid for a random gap
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_paced(input logic mode, input logic [spdlq_pkg::IDX_W-1:0] idx,
                            input logic [spdlq_pkg::DUTY_W-1:0] duty);
    send_item(mode, idx, duty);
    pace_sender();
  endtask

  // Stop offering and wait until every predicted level has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_levels != 0);
  endtask

  task automatic write_reg(input logic [spdlq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spdlq_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [spdlq_pkg::CFG_DATA_W-1:0] pick_signal_period();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'($urandom_range(2, 16));
      3, 4:    return 16'($urandom_range(1, 1024));
      5:       return 16'd1024;
      6:       return 16'($urandom_range(1025, 2047));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [spdlq_pkg::CFG_DATA_W-1:0] pick_pwm_span();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd2;
      3:       return 16'($urandom_range(3, 300));
      4:       return 16'd256;
      5:       return 16'($urandom_range(257, 65535));
      6:       return 16'd65535;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mix of plain, over-range, tie-prone and extreme duty fractions
  function automatic logic [spdlq_pkg::DUTY_W-1:0] pick_duty();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 17'($urandom_range(0, 65536));
      4, 5:       return 17'($urandom_range(0, 131071));
      6, 7:       return 17'(128 * $urandom_range(0, 512));
      8: begin
        case ($urandom_range(0, 4))
          0:       return 17'd0;
          1:       return 17'd65535;
          2:       return 17'd65536;
          3:       return 17'd65537;
          default: return 17'd131071;
        endcase
      end
      default:    return 17'(65536 - $urandom_range(0, 300));
    endcase
  endfunction

  // Receiver: random stall rate that shifts over time, plus one long hold-off
  initial begin : result_sink
    int hold_left;
    int pace_pct;
    int tick;
    hold_left = 0;
    pace_pct = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 300 == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    pace_pct = 0;
          2:       pace_pct = 25;
          3:       pace_pct = 60;
          default: pace_pct = 90;
        endcase
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < pace_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("sine_pwm_duty_level_quantizer: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: sine quadrants and level edges, ties included
    send_paced(spdlq_pkg::MODE_SINE, 10'd0, 17'h1FFFF);
    send_paced(spdlq_pkg::MODE_SINE, 10'd256, 17'd0);
    send_paced(spdlq_pkg::MODE_SINE, 10'd512, 17'd0);
    send_paced(spdlq_pkg::MODE_SINE, 10'd768, 17'd0);
    send_paced(spdlq_pkg::MODE_SINE, 10'd1023, 17'd0);
    send_paced(spdlq_pkg::MODE_FIXED, 10'h3FF, 17'd0);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd256);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd640);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd32768);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd65535);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd65536);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd131071);
    drain_results();

    // Zero signal period reads as one sample per turn
    write_reg(spdlq_pkg::REG_SIGNAL_PERIOD, 16'd0);
    send_paced(spdlq_pkg::MODE_SINE, 10'd5, 17'd0);
    drain_results();
    // Oversized period saturates
    write_reg(spdlq_pkg::REG_SIGNAL_PERIOD, 16'hFFFF);
    send_paced(spdlq_pkg::MODE_SINE, 10'd513, 17'd0);
    drain_results();
    // Index beyond the period wraps
    write_reg(spdlq_pkg::REG_SIGNAL_PERIOD, 16'd3);
    send_paced(spdlq_pkg::MODE_SINE, 10'd1023, 17'd0);
    send_paced(spdlq_pkg::MODE_SINE, 10'd1, 17'd0);
    drain_results();
    // Unmapped register writes leave the level count alone
    write_reg(REG_UNMAPPED_LO, 16'd0);
    write_reg(REG_UNMAPPED_HI, 16'd7);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd32768);
    drain_results();
    // No levels, a single level, two levels with a tie, widest count
    write_reg(spdlq_pkg::REG_PWM_SPAN, 16'd0);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd65536);
    drain_results();
    write_reg(spdlq_pkg::REG_PWM_SPAN, 16'd1);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd65536);
    drain_results();
    write_reg(spdlq_pkg::REG_PWM_SPAN, 16'd2);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd32768);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd32769);
    drain_results();
    write_reg(spdlq_pkg::REG_PWM_SPAN, 16'd65535);
    send_paced(spdlq_pkg::MODE_FIXED, 10'd0, 17'd65535);
    send_paced(spdlq_pkg::MODE_SINE, 10'd300, 17'd0);
    drain_results();

    // Random phases, each possibly under new settings and under a new sender pace
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if ($urandom_range(0, 4) != 0) begin
        write_reg(spdlq_pkg::REG_SIGNAL_PERIOD, pick_signal_period());
      end
      if ($urandom_range(0, 4) != 0) write_reg(spdlq_pkg::REG_PWM_SPAN, pick_pwm_span());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(8'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), 16'($urandom));
      end
      case (phase % 4)
        0:       gap_max = 0;
        1:       gap_max = 3;
        2:       gap_max = 20;
        default: gap_max = 100;
      endcase
      if (phase == 2) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_paced(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)), pick_duty());
      end
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sine_pwm_duty_level_quantizer: match");
    end else begin
      $display("sine_pwm_duty_level_quantizer: mismatch");
    end
    $finish;
  end

endmodule
